// File: rtl/core/hwk_pkg.sv
// hwk_pkg: shared types, stage counts and constants for the wheel kinematics pipeline.
// No dependencies; imported by every module under rtl/core.
package hwk_pkg;

	localparam int VEL_W        = 16;
	localparam int TH_W         = 14;
	localparam int ANG_W        = 17;
	localparam int TRIG_W       = 18;
	localparam int RPM_W        = 19;
	localparam int CFG_W        = 15;
	localparam int RADIUS_W     = 10;
	localparam int FRONT_W      = 9;
	localparam int GAIN_W       = 20;

	localparam int LIM_STAGES   = 4;
	localparam int SINE_STAGES  = 9;
	localparam int WHEEL_STAGES = 7;
	localparam int PIPE_STAGES  = 1 + 2 * LIM_STAGES + SINE_STAGES + WHEEL_STAGES;

	localparam int NUM_ANGLES   = 6;
	localparam int NUM_WHEELS   = 4;

	localparam logic [GAIN_W-1:0] GAIN_MECANUM = 20'd534035;
	localparam logic [GAIN_W-1:0] GAIN_OMNI    = 20'd589010;
	localparam logic [23:0]       RECIP_90     = 24'd11930465;

	typedef logic signed [VEL_W-1:0]  vel_t;
	typedef logic signed [ANG_W-1:0]  ang_t;
	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic signed [RPM_W-1:0]  rpm_t;

	typedef struct packed {
		vel_t                   vx;
		vel_t                   vy;
		vel_t                   w;
		logic signed [TH_W-1:0] th;
	} cmd_t;

	typedef enum logic [2:0] {
		REG_DRIVE_MODE     = 3'd0,
		REG_FIELD_ORIENTED = 3'd1,
		REG_VX_MAX         = 3'd2,
		REG_VY_MAX         = 3'd3,
		REG_BODY_RADIUS    = 3'd4,
		REG_OMNI_FRONT     = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		MODE_MECANUM = 1'b0,
		MODE_OMNI    = 1'b1
	} drive_mode_t;

endpackage

// File: rtl/core/hwk_limit.sv
// hwk_limit: clamps one velocity component to its limit and rescales the other one,
// multiply then a 15-bit restoring divide over three stages. Uses hwk_pkg.
module hwk_limit import hwk_pkg::*; (
	input  logic                  clk,
	input  logic [LIM_STAGES-1:0] en,
	input  logic                  swap,
	input  logic [CFG_W-1:0]      lim,
	input  cmd_t                  cmd,
	output cmd_t                  res
);

	function automatic logic [20:0] div5(input logic [15:0] r, input logic [4:0] bits,
		input logic [15:0] d);
		logic [16:0] t;
		logic [15:0] rr;
		logic [4:0]  q;
		rr = r;
		q  = '0;
		for (int i = 4; i >= 0; i--) begin
			t = {rr, bits[i]};
			if (t >= {1'b0, d}) begin
				t    = t - {1'b0, d};
				q[i] = 1'b1;
			end
			rr = t[15:0];
		end
		return {q, rr};
	endfunction

	vel_t        lead, other;
	logic [15:0] mag, om;

	cmd_t        cmd_s1, cmd_s2, cmd_s3, res_s4;
	logic [30:0] prod_s1;
	logic [15:0] mag_s1, mag_s2, mag_s3;
	logic        over_s1, over_s2, over_s3;
	logic [CFG_W-1:0] lim_s1, lim_s2, lim_s3;
	logic [15:0] rem_s2, rem_s3;
	logic [4:0]  quo_s2;
	logic [9:0]  quo_s3;
	logic [9:0]  lo_s2;
	logic [4:0]  lo_s3;

	logic [20:0] d2, d3, d4;
	logic [14:0] quo;
	vel_t        lead3, other3, lead_new, other_new, lim_v, quo_v;
	cmd_t        sel;

	always_comb begin
		lead  = swap ? cmd.vy : cmd.vx;
		other = swap ? cmd.vx : cmd.vy;
		mag   = lead[VEL_W-1]  ? 16'(-lead)  : 16'(lead);
		om    = other[VEL_W-1] ? 16'(-other) : 16'(other);
	end

	assign d2  = div5(prod_s1[30:15], prod_s1[14:10], mag_s1);
	assign d3  = div5(rem_s2, lo_s2[9:5], mag_s2);
	assign d4  = div5(rem_s3, lo_s3, mag_s3);
	assign quo = {quo_s3, d4[20:16]};

	always_comb begin
		lead3     = swap ? cmd_s3.vy : cmd_s3.vx;
		other3    = swap ? cmd_s3.vx : cmd_s3.vy;
		lim_v     = {1'b0, lim_s3};
		quo_v     = {1'b0, quo};
		lead_new  = lead3[VEL_W-1]  ? -lim_v : lim_v;
		other_new = other3[VEL_W-1] ? -quo_v : quo_v;
		sel       = cmd_s3;
		if (over_s3) begin
			if (swap) begin
				sel.vy = lead_new;
				sel.vx = other_new;
			end else begin
				sel.vx = lead_new;
				sel.vy = other_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cmd_s1  <= cmd;
			prod_s1 <= 31'(om) * 31'(lim);
			mag_s1  <= mag;
			over_s1 <= mag > 16'(lim);
			lim_s1  <= lim;
		end
		if (en[1]) begin
			cmd_s2  <= cmd_s1;
			mag_s2  <= mag_s1;
			over_s2 <= over_s1;
			lim_s2  <= lim_s1;
			quo_s2  <= d2[20:16];
			rem_s2  <= d2[15:0];
			lo_s2   <= prod_s1[9:0];
		end
		if (en[2]) begin
			cmd_s3  <= cmd_s2;
			mag_s3  <= mag_s2;
			over_s3 <= over_s2;
			lim_s3  <= lim_s2;
			quo_s3  <= {quo_s2, d3[20:16]};
			rem_s3  <= d3[15:0];
			lo_s3   <= lo_s2[4:0];
		end
		if (en[3]) begin
			res_s4  <= sel;
		end
	end

	assign res = res_s4;

endmodule

// File: rtl/core/hwk_sine.sv
// hwk_sine: Q16 sine of an angle in 1/16 degree; range reduction, quadrant fold and a
// Horner-evaluated quarter-wave polynomial, one multiply per stage. Uses hwk_pkg.
module hwk_sine import hwk_pkg::*; (
	input  logic                   clk,
	input  logic [SINE_STAGES-1:0] en,
	input  ang_t                   angle,
	output trig_t                  sine
);

	logic [16:0] u;
	logic [12:0] r;
	logic [1:0]  quad;
	logic [10:0] f, x;
	logic [22:0] n;
	logic [46:0] pr3;
	logic [33:0] pr4;
	logic [20:0] pr5;
	logic [25:0] pr6;
	logic [29:0] pr7;
	logic [32:0] pr8;
	logic [33:0] pr9;
	logic [16:0] pc;

	logic [12:0] r_s1;
	logic [10:0] x_s2;
	logic        neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic [16:0] t_s3, t_s4, t_s5, t_s6, t_s7, t_s8;
	logic [16:0] t2_s4, t2_s5, t2_s6, t2_s7;
	logic [8:0]  p1_s5;
	logic [12:0] p2_s6;
	logic [15:0] p3_s7;
	logic [16:0] p4_s8;
	trig_t       sine_s9;

	always_comb begin
		u = 17'(angle + 17'sd11520);
		if (u >= 17'd28800)      r = 13'(u - 17'd28800);
		else if (u >= 17'd23040) r = 13'(u - 17'd23040);
		else if (u >= 17'd17280) r = 13'(u - 17'd17280);
		else if (u >= 17'd11520) r = 13'(u - 17'd11520);
		else if (u >= 17'd5760)  r = 13'(u - 17'd5760);
		else                     r = 13'(u);
	end

	always_comb begin
		if (r_s1 >= 13'd4320) begin
			quad = 2'd3;
			f    = 11'(r_s1 - 13'd4320);
		end else if (r_s1 >= 13'd2880) begin
			quad = 2'd2;
			f    = 11'(r_s1 - 13'd2880);
		end else if (r_s1 >= 13'd1440) begin
			quad = 2'd1;
			f    = 11'(r_s1 - 13'd1440);
		end else begin
			quad = 2'd0;
			f    = 11'(r_s1);
		end
		x = quad[0] ? 11'(11'd1440 - f) : f;
	end

	always_comb begin
		n   = {x_s2, 12'b0} + 23'd45;
		pr3 = 47'(n) * 47'(RECIP_90);
		pr4 = 34'(t_s3) * 34'(t_s3);
		pr5 = 21'(t2_s4) * 21'd11;
		pr6 = 26'(p1_s5) * 26'(t2_s5);
		pr7 = 30'(p2_s6) * 30'(t2_s6);
		pr8 = 33'(p3_s7) * 33'(t2_s7);
		pr9 = 34'(p4_s8) * 34'(t_s8);
		pc  = (pr9[33:16] > 18'd65536) ? 17'd65536 : pr9[32:16];
	end

	always_ff @(posedge clk) begin
		if (en[0]) r_s1 <= r;
		if (en[1]) begin
			x_s2   <= x;
			neg_s2 <= quad[1];
		end
		if (en[2]) begin
			t_s3   <= pr3[46:30];
			neg_s3 <= neg_s2;
		end
		if (en[3]) begin
			t_s4   <= t_s3;
			t2_s4  <= pr4[32:16];
			neg_s4 <= neg_s3;
		end
		if (en[4]) begin
			p1_s5  <= 9'(10'd307 - 10'(pr5 >> 16));
			t_s5   <= t_s4;
			t2_s5  <= t2_s4;
			neg_s5 <= neg_s4;
		end
		if (en[5]) begin
			p2_s6  <= 13'(14'd5223 - 14'(pr6 >> 16));
			t_s6   <= t_s5;
			t2_s6  <= t2_s5;
			neg_s6 <= neg_s5;
		end
		if (en[6]) begin
			p3_s7  <= 16'(17'd42334 - 17'(pr7 >> 16));
			t_s7   <= t_s6;
			t2_s7  <= t2_s6;
			neg_s7 <= neg_s6;
		end
		if (en[7]) begin
			p4_s8  <= 17'(18'd102944 - 18'(pr8 >> 16));
			t_s8   <= t_s7;
			neg_s8 <= neg_s7;
		end
		if (en[8]) begin
			sine_s9 <= neg_s8 ? -trig_t'({1'b0, pc}) : trig_t'({1'b0, pc});
		end
	end

	assign sine = sine_s9;

endmodule

// File: rtl/core/hwk_trig.sv
// hwk_trig: builds the six wheel angles (sine/cosine pairs) and runs six sine pipelines
// while the command rides along. Uses hwk_pkg and hwk_sine.
module hwk_trig import hwk_pkg::*; (
	input  logic                   clk,
	input  logic [SINE_STAGES-1:0] en,
	input  logic                   drive_mode,
	input  logic                   field_oriented,
	input  logic [FRONT_W-1:0]     omni_front,
	input  cmd_t                   cmd,
	output cmd_t                   cmd_out,
	output trig_t                  sc [NUM_ANGLES]
);

	ang_t th, base;
	ang_t ang [NUM_ANGLES];
	cmd_t cmd_s [SINE_STAGES];

	always_comb begin
		th   = field_oriented ? ang_t'(cmd.th) : '0;
		base = ang_t'({omni_front, 4'b0}) + th;
		for (int k = 0; k < NUM_ANGLES / 2; k++) begin
			ang[2*k] = base + ang_t'(1920 * k);
		end
		if (drive_mode == MODE_MECANUM) begin
			ang[0] = 17'sd720 + th;
			ang[2] = 17'sd720 - th;
		end
		for (int k = 0; k < NUM_ANGLES / 2; k++) begin
			ang[2*k+1] = ang[2*k] + 17'sd1440;
		end
	end

	for (genvar j = 0; j < NUM_ANGLES; j++) begin : g_sine
		hwk_sine u_sine (
			.clk   (clk),
			.en    (en),
			.angle (ang[j]),
			.sine  (sc[j])
		);
	end

	for (genvar s = 0; s < SINE_STAGES; s++) begin : g_cmd
		always_ff @(posedge clk) begin
			if (en[s]) cmd_s[s] <= (s == 0) ? cmd : cmd_s[(s == 0) ? 0 : s - 1];
		end
	end

	assign cmd_out = cmd_s[SINE_STAGES-1];

endmodule

// File: rtl/core/hwk_wheel.sv
// hwk_wheel: mixes velocities with sine/cosine into per-wheel sums, scales by the wheel
// gain in split partial products, rounds and saturates to 1/16 rpm. Uses hwk_pkg.
module hwk_wheel import hwk_pkg::*; (
	input  logic                    clk,
	input  logic [WHEEL_STAGES-1:0] en,
	input  logic                    drive_mode,
	input  logic [RADIUS_W-1:0]     body_radius,
	input  cmd_t                    cmd,
	input  trig_t                   sc [NUM_ANGLES],
	output rpm_t                    rpm [NUM_WHEELS]
);

	typedef logic signed [33:0] prod_t;
	typedef logic signed [26:0] rot_t;
	typedef logic signed [34:0] dsum_t;
	typedef logic signed [45:0] acc_t;

	logic [GAIN_W-1:0] gain;
	prod_t             m [NUM_ANGLES];
	dsum_t             d [NUM_WHEELS];
	acc_t              a [NUM_WHEELS];
	logic [43:0]       mag [NUM_WHEELS];
	logic [64:0]       sum [NUM_WHEELS];
	rpm_t              sat [NUM_WHEELS];

	prod_t       m_s1 [NUM_ANGLES];
	rot_t        wr_s1, wr_s2;
	dsum_t       d_s2 [NUM_WHEELS];
	acc_t        a_s3 [NUM_WHEELS];
	logic [43:0] mag_s4 [NUM_WHEELS];
	logic        neg_s4 [NUM_WHEELS];
	logic [41:0] plo_s5 [NUM_WHEELS];
	logic [41:0] phi_s5 [NUM_WHEELS];
	logic        neg_s5 [NUM_WHEELS];
	logic [20:0] q_s6 [NUM_WHEELS];
	logic        neg_s6 [NUM_WHEELS];
	rpm_t        rpm_s7 [NUM_WHEELS];

	assign gain = (drive_mode == MODE_OMNI) ? GAIN_OMNI : GAIN_MECANUM;

	always_comb begin
		for (int j = 0; j < NUM_ANGLES; j++) begin
			m[j] = prod_t'((j % 2 == 0) ? cmd.vx : cmd.vy) * prod_t'(sc[j]);
		end
	end

	always_comb begin
		if (drive_mode == MODE_MECANUM) begin
			d[0] = dsum_t'(m_s1[1]) - dsum_t'(m_s1[0]);
			d[1] = -dsum_t'(m_s1[2]) - dsum_t'(m_s1[3]);
			d[2] = dsum_t'(m_s1[0]) - dsum_t'(m_s1[1]);
			d[3] = dsum_t'(m_s1[2]) + dsum_t'(m_s1[3]);
		end else begin
			d[0] = dsum_t'(m_s1[1]) - dsum_t'(m_s1[0]);
			d[1] = dsum_t'(m_s1[3]) - dsum_t'(m_s1[2]);
			d[2] = dsum_t'(m_s1[5]) - dsum_t'(m_s1[4]);
			d[3] = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_WHEELS; i++) begin
			a[i]   = acc_t'(d_s2[i]) * acc_t'(1000) + (acc_t'(wr_s2) <<< 16);
			mag[i] = a_s3[i][45] ? 44'(-a_s3[i]) : 44'(a_s3[i]);
			sum[i] = {1'b0, phi_s5[i], 22'b0} + 65'(plo_s5[i]) + (65'(1) << 43);
			if (neg_s6[i]) begin
				sat[i] = (q_s6[i] > 21'd262144) ? rpm_t'(-262144) : rpm_t'(-$signed({1'b0, q_s6[i]}));
			end else begin
				sat[i] = (q_s6[i] > 21'd262143) ? rpm_t'(262143) : rpm_t'(q_s6[i]);
			end
		end
		if (drive_mode == MODE_OMNI) sat[NUM_WHEELS-1] = '0;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			m_s1  <= m;
			wr_s1 <= rot_t'(cmd.w) * rot_t'({1'b0, body_radius});
		end
		if (en[1]) begin
			d_s2  <= d;
			wr_s2 <= wr_s1;
		end
		if (en[2]) a_s3 <= a;
		for (int i = 0; i < NUM_WHEELS; i++) begin
			if (en[3]) begin
				mag_s4[i] <= mag[i];
				neg_s4[i] <= a_s3[i][45];
			end
			if (en[4]) begin
				plo_s5[i] <= 42'(mag_s4[i][21:0]) * 42'(gain);
				phi_s5[i] <= 42'(mag_s4[i][43:22]) * 42'(gain);
				neg_s5[i] <= neg_s4[i];
			end
			if (en[5]) begin
				q_s6[i]   <= sum[i][64:44];
				neg_s6[i] <= neg_s5[i];
			end
		end
		if (en[6]) rpm_s7 <= sat;
	end

	assign rpm = rpm_s7;

endmodule

// File: rtl/core/holonomic_wheel_kinematics.sv
// holonomic_wheel_kinematics: top level; config registers, input stage, two limiters,
// trig pipeline, wheel mixer and stall ripple. Uses hwk_pkg, hwk_limit, hwk_trig, hwk_wheel.
//
//   channel | signals                                   | beat taken when
//   cmd     | vel_x vel_y omega heading                 | cmd_valid & !cmd_stall
//   rpm     | wheel1_rpm .. wheel4_rpm                  | rpm_valid & !rpm_stall
//   cfg     | cfg_we cfg_index cfg_data                 | cfg_we
//
// One beat per cycle sustained while rpm_stall is low; each beat runs through every stage.
// Latency is set by the 15-bit divide in each limiter and the Horner multiplies of sine.
// Each stage holds only while it is full and the stage after it holds, so bubbles close up.
// arst_n clears valid bits and loads config registers with defaults; payload registers are not reset.
module holonomic_wheel_kinematics import hwk_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  logic signed [VEL_W-1:0] vel_x,
	input  logic signed [VEL_W-1:0] vel_y,
	input  logic signed [VEL_W-1:0] omega,
	input  logic signed [TH_W-1:0]  heading,
	output logic                   rpm_valid,
	input  logic                   rpm_stall,
	output logic signed [RPM_W-1:0] wheel1_rpm,
	output logic signed [RPM_W-1:0] wheel2_rpm,
	output logic signed [RPM_W-1:0] wheel3_rpm,
	output logic signed [RPM_W-1:0] wheel4_rpm,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int LIM1_BASE  = 1;
	localparam int LIM2_BASE  = LIM1_BASE + LIM_STAGES;
	localparam int TRIG_BASE  = LIM2_BASE + LIM_STAGES;
	localparam int WHEEL_BASE = TRIG_BASE + SINE_STAGES;

	logic                drive_mode_q;
	logic                field_oriented_q;
	logic [CFG_W-1:0]    vx_max_q, vy_max_q;
	logic [RADIUS_W-1:0] body_radius_q;
	logic [FRONT_W-1:0]  omni_front_q;

	logic [PIPE_STAGES-1:0] vld_q;
	logic [PIPE_STAGES-1:0] en;
	cmd_t  cmd_s0, lim1, lim2, trig_cmd;
	trig_t sc [NUM_ANGLES];
	rpm_t  rpm [NUM_WHEELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_mode_q     <= 1'b0;
			field_oriented_q <= 1'b1;
			vx_max_q         <= 15'd1536;
			vy_max_q         <= 15'd1536;
			body_radius_q    <= 10'd242;
			omni_front_q     <= 9'd90;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DRIVE_MODE:     drive_mode_q     <= cfg_data[0];
				REG_FIELD_ORIENTED: field_oriented_q <= cfg_data[0];
				REG_VX_MAX:         vx_max_q         <= cfg_data;
				REG_VY_MAX:         vy_max_q         <= cfg_data;
				REG_BODY_RADIUS:    body_radius_q    <= cfg_data[RADIUS_W-1:0];
				REG_OMNI_FRONT:     omni_front_q     <= cfg_data[FRONT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		en[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || !rpm_stall;
		for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < PIPE_STAGES; k++) begin
				if (en[k]) vld_q[k] <= (k == 0) ? cmd_valid : vld_q[(k == 0) ? 0 : k - 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cmd_s0.vx <= vel_x;
			cmd_s0.vy <= vel_y;
			cmd_s0.w  <= omega;
			cmd_s0.th <= heading;
		end
	end

	hwk_limit u_lim_x (
		.clk  (clk),
		.en   (en[LIM1_BASE +: LIM_STAGES]),
		.swap (1'b0),
		.lim  (vx_max_q),
		.cmd  (cmd_s0),
		.res  (lim1)
	);

	hwk_limit u_lim_y (
		.clk  (clk),
		.en   (en[LIM2_BASE +: LIM_STAGES]),
		.swap (1'b1),
		.lim  (vy_max_q),
		.cmd  (lim1),
		.res  (lim2)
	);

	hwk_trig u_trig (
		.clk            (clk),
		.en             (en[TRIG_BASE +: SINE_STAGES]),
		.drive_mode     (drive_mode_q),
		.field_oriented (field_oriented_q),
		.omni_front     (omni_front_q),
		.cmd            (lim2),
		.cmd_out        (trig_cmd),
		.sc             (sc)
	);

	hwk_wheel u_wheel (
		.clk         (clk),
		.en          (en[WHEEL_BASE +: WHEEL_STAGES]),
		.drive_mode  (drive_mode_q),
		.body_radius (body_radius_q),
		.cmd         (trig_cmd),
		.sc          (sc),
		.rpm         (rpm)
	);

	assign cmd_stall  = !en[0];
	assign rpm_valid  = vld_q[PIPE_STAGES-1];
	assign wheel1_rpm = rpm[0];
	assign wheel2_rpm = rpm[1];
	assign wheel3_rpm = rpm[2];
	assign wheel4_rpm = rpm[3];

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (&vld_q) && rpm_stall)
		else $error("input stalled with a bubble in the pipeline");

	a_drain_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		rpm_valid && !rpm_stall && !vld_q[PIPE_STAGES-2] |=> !rpm_valid)
		else $error("output beat repeated after it was taken");

	a_valid_from_prev: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rpm_valid) |-> $past(vld_q[PIPE_STAGES-2]))
		else $error("output valid appeared without a beat in the stage before");

endmodule
